// ----- hdl/pnvs_pkg.sv -----
// ----------------------------------------------------------------------------
// pnvs_pkg
// shared types, codes and constants of the probabilistic nearest-value snap
// ----------------------------------------------------------------------------
package pnvs_pkg;

  // default number of target table entries
  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  // field widths
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned ENTRY_W = 6;
  localparam int unsigned TOL_W   = 15;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned MARGIN_W = 18;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT = 1'd1;

  // stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 16;

  // noise source
  localparam logic [15:0] LFSR_RESET = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  // one in q8.8
  localparam logic [8:0] Q_ONE = 9'd256;

  typedef enum logic {
    FUNC_PITCH = 1'b0,
    FUNC_LOAD  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch pitch and table count
    logic write;   // write one table entry
    logic rd_en;   // read next table entry
    logic emit;    // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // no entries take part in the search
    logic last;      // read address is at the last entry
    logic out_free;  // output register can take a result
  } status_t;

endpackage

// ----- hdl/pnvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// pnvs_ctrl
// controller: sequences item acceptance, the table scan and the result
// ----------------------------------------------------------------------------
module pnvs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              func_i,
  input  pnvs_pkg::status_t status_i,
  output pnvs_pkg::cmd_t    cmd_o
);
  import pnvs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && func_e'(func_i) == FUNC_PITCH) begin
          state_d = status_i.empty ? ST_DECIDE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.start   = s_axis_tvalid && func_e'(func_i) == FUNC_PITCH;
        cmd_o.write   = s_axis_tvalid && func_e'(func_i) == FUNC_LOAD;
      end
      ST_SEARCH: cmd_o.rd_en = 1'b1;
      ST_DRAIN:  cmd_o = '0;
      ST_DECIDE: cmd_o.emit = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/pnvs_dpath.sv -----
// ----------------------------------------------------------------------------
// pnvs_dpath
// datapath: config registers, target table, distance search, noise source
// and output register
// ----------------------------------------------------------------------------
module pnvs_dpath #(
  parameter int unsigned TABLE_DEPTH = pnvs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pnvs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pnvs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [pnvs_pkg::ENTRY_W-1:0]        entry_index_i,
  input  logic signed [pnvs_pkg::PITCH_W-1:0] pitch_value_i,
  input  pnvs_pkg::cmd_t                      cmd_i,
  output pnvs_pkg::status_t                   status_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic signed [pnvs_pkg::PITCH_W-1:0] pitch_out_o,
  output logic                                snapped_o
);
  import pnvs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = (CW > COUNT_W) ? CW : COUNT_W;

  // configuration registers
  logic [TOL_W-1:0]   tolerance_q;
  logic [COUNT_W-1:0] table_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q   <= '0;
      table_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOLERANCE:   tolerance_q   <= cfg_data_i[TOL_W-1:0];
        REG_TABLE_COUNT: table_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // entries searched, clipped to the table depth
  logic [NW-1:0] count_ext;
  logic [CW-1:0] n_clip;
  assign count_ext = NW'(table_count_q);
  assign n_clip    = (count_ext > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ext);

  // target table
  logic [PITCH_W-1:0] mem [TABLE_DEPTH];
  logic               wr_ok;
  assign wr_ok = 32'(entry_index_i) < 32'(TABLE_DEPTH);

  logic [AW-1:0]      addr_q;
  logic [PITCH_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_ok) begin
      mem[AW'(entry_index_i)] <= pitch_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_q];
    end
  end

  // scan control
  logic [CW-1:0] n_q;
  logic          cmp_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      n_q       <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        addr_q <= '0;
        n_q    <= n_clip;
      end else if (cmd_i.rd_en) begin
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  // distance compare, strict less keeps the lowest index on a tie
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [PITCH_W:0]   diff;
  logic [DIST_W-1:0]         abs_dist;
  logic [DIST_W-1:0]         best_dist_q;
  logic [PITCH_W-1:0]        best_val_q;
  logic                      have_best_q;

  assign diff     = (PITCH_W+1)'($signed(rdata_q)) - (PITCH_W+1)'(pitch_q);
  assign abs_dist = diff[PITCH_W] ? DIST_W'(-diff) : DIST_W'(diff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pitch_q <= pitch_value_i;
    end
    if (cmp_vld_q && (!have_best_q || abs_dist < best_dist_q)) begin
      best_dist_q <= abs_dist;
      best_val_q  <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
    end else if (cmd_i.start) begin
      have_best_q <= 1'b0;
    end else if (cmp_vld_q) begin
      have_best_q <= 1'b1;
    end
  end

  // snap decision
  logic signed [MARGIN_W-1:0] margin;
  logic [15:0]                lfsr_q, lfsr_next;
  logic                       in_window;
  logic                       snap;

  assign margin    = $signed(MARGIN_W'(best_dist_q)) - $signed(MARGIN_W'(tolerance_q));
  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
  assign in_window = !margin[MARGIN_W-1] && (margin[MARGIN_W-2:8] == '0);
  assign snap      = have_best_q && (margin[MARGIN_W-1] ||
                     (in_window && ({1'b0, lfsr_next[7:0]} < (Q_ONE - margin[8:0]))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_RESET;
    end else if (cmd_i.emit && have_best_q && in_window) begin
      lfsr_q <= lfsr_next;
    end
  end

  // output register
  logic               out_valid_q;
  logic [PITCH_W-1:0] out_pitch_q;
  logic               out_snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pitch_q <= snap ? best_val_q : pitch_q;
      out_snap_q  <= snap;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign pitch_out_o = out_pitch_q;
  assign snapped_o   = out_snap_q;

  assign status_o.empty    = (table_count_q == '0);
  assign status_o.last     = (CW'(addr_q) + CW'(1)) == n_q;
  assign status_o.out_free = !out_valid_q || m_ready_i;

endmodule

// ----- hdl/probabilistic_nearest_value_snap.sv -----
// ----------------------------------------------------------------------------
// probabilistic_nearest_value_snap
// snaps q8.8 pitches to the nearest target table entry, with a random
// decision inside one unit of tolerance
// ----------------------------------------------------------------------------
// operation: a pitch transaction is accepted in idle, then the table is scanned
//   one entry a cycle through its single read port over table_count clipped
//   to TABLE_DEPTH entries, the read pipeline is drained and the result is
//   handed to the output register once it is free; with an empty table the
//   scan is skipped; no new transaction is accepted until then; a table load
//   transaction leaves the block idle and gives no result
// reset: asynchronous, active low; clears config registers, controller and
//   output valid, sets the noise lfsr to its seed; table content is kept
// ----------------------------------------------------------------------------
module probabilistic_nearest_value_snap #(
  parameter int unsigned TABLE_DEPTH = pnvs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes, no read-back
  input  logic                             cfg_we_i,
  input  logic [pnvs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pnvs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pnvs_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // entry_index, pitch_value, pad
  input  logic                             s_axis_tuser,  // func
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pnvs_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // pitch_out
  output logic                             m_axis_tuser   // snapped
);
  import pnvs_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [ENTRY_W-1:0]        entry_index;
  logic signed [PITCH_W-1:0] pitch_value;
  logic signed [PITCH_W-1:0] pitch_out;

  // unpack the input transaction; pad bits above the pitch are ignored
  assign entry_index = s_axis_tdata[ENTRY_W-1:0];
  assign pitch_value = $signed(s_axis_tdata[ENTRY_W +: PITCH_W]);

  // controller: idle accepts transactions, then scan, drain the read
  // pipeline and hand the result to the output register
  pnvs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .func_i        (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // datapath: table memory, nearest-entry search, lfsr and output register;
  // the output register lets the next transaction in while a result waits
  pnvs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index),
    .pitch_value_i (pitch_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .pitch_out_o   (pitch_out),
    .snapped_o     (m_axis_tuser)
  );

  assign m_axis_tdata = pitch_out;

endmodule

// ----- hdl/pnvs_checker.sv -----
// ----------------------------------------------------------------------------
// pnvs_checker
// port-level checks of the probabilistic nearest-value snap
// ----------------------------------------------------------------------------
module pnvs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pnvs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser
);
  import pnvs_pkg::*;

  // a pitch transaction blocks the input while the table is scanned
  a_pitch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_PITCH) |=> !s_axis_tready)
    else $error("input ready after a pitch transaction");

  // a table load leaves the input ready for the next transaction
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_LOAD) |=> s_axis_tready)
    else $error("input not ready after a load transaction");

  // a new result only appears after the input was held off for a pitch
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a pitch in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind probabilistic_nearest_value_snap pnvs_checker u_pnvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of probabilistic_nearest_value_snap: drives table
// load and pitch transactions, predicts every result with a cycle-free model
// of the nearest-entry search and the lfsr draw, and compares each result
// transaction field by field
// ----------------------------------------------------------------------------
module testbench;
  import pnvs_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  // long enough to cover any search still in flight
  localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 16;

  // one expected result transaction
  typedef struct packed {
    logic [PITCH_W-1:0] pitch_out;
    logic               snapped;
  } snap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // input stream
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // entry_index, pitch_value, pad
  logic                 s_axis_tuser = 1'b0; // func

  // result stream
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // pitch_out
  logic                 m_axis_tuser;        // snapped

  // predictor state, updated at each accepted transaction or register write
  logic signed [PITCH_W-1:0] target_q [TABLE_DEPTH];
  logic [15:0]               lfsr_q = LFSR_RESET;
  logic [TOL_W-1:0]          tol_q = '0;
  logic [COUNT_W-1:0]        count_q = '0;

  snap_res_t expected_q [$];
  int unsigned err_count = 0;

  // idling control for the sender and the sink process
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int unsigned hold_left = 0;

  always #6 clk = ~clk;

  probabilistic_nearest_value_snap #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic report_mismatch(string what);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // nearest-entry search, tolerance margin and random snap decision
  function automatic snap_res_t predict_snap(logic signed [PITCH_W-1:0] pitch);
    snap_res_t   res;
    int          n, best_idx, best_dist, cur_dist, margin;
    logic [15:0] nxt;
    res.pitch_out = pitch;
    res.snapped   = 1'b0;
    n = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : count_q;
    // empty table: pass through, lfsr untouched
    if (n > 0) begin
      best_idx = 0;
      best_dist = int'(target_q[0]) - int'(pitch);
      if (best_dist < 0) best_dist = -best_dist;
      for (int i = 1; i < n; i++) begin
        cur_dist = int'(target_q[i]) - int'(pitch);
        if (cur_dist < 0) cur_dist = -cur_dist;
        // strict compare keeps the lowest index on a tie
        if (cur_dist < best_dist) begin
          best_dist = cur_dist;
          best_idx  = i;
        end
      end
      margin = best_dist - int'(tol_q);
      if (margin < 0) begin
        res.snapped = 1'b1;
      end else if (margin < int'(Q_ONE)) begin
        // galois step, only inside one unit of tolerance
        nxt = {1'b0, lfsr_q[15:1]};
        if (lfsr_q[0]) nxt = nxt ^ LFSR_TAPS;
        lfsr_q = nxt;
        res.snapped = int'(nxt[7:0]) < int'(Q_ONE) - margin;
      end
      if (res.snapped) res.pitch_out = target_q[best_idx];
    end
    return res;
  endfunction

  // offer one transaction, wait for the handshake, then update the predictor
  task automatic send_item(func_e func, logic [ENTRY_W-1:0] idx, logic [PITCH_W-1:0] value);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, value, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (func == FUNC_LOAD) target_q[idx] = value;
    else expected_q.push_back(predict_snap(value));
  endtask

  // sender pause until every pending result has been taken
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // registers only change while the block is idle
  task automatic configure(int unsigned tol, int unsigned count);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TOLERANCE;
    cfg_data_i <= CFG_DATA_W'(tol);
    @(posedge clk);
    tol_q = TOL_W'(tol);
    cfg_idx_i  <= REG_TABLE_COUNT;
    cfg_data_i <= CFG_DATA_W'(COUNT_W'(count));
    @(posedge clk);
    count_q = COUNT_W'(count);
    cfg_we_i <= 1'b0;
  endtask

  // mostly pitches near an active entry, some anywhere, some table reloads
  task automatic run_phase(int unsigned items, int unsigned tol, int unsigned count);
    int unsigned lim;
    int          delta;
    logic [PITCH_W-1:0] pv;
    configure(tol, count);
    lim = (count == 0 || count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    repeat (items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(FUNC_LOAD, ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1)),
                  PITCH_W'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 65) begin
          // land around the tolerance edge of some entry
          delta = int'(tol_q) + int'($urandom_range(0, 320)) - 32;
          if ($urandom_range(0, 1)) delta = -delta;
          pv = PITCH_W'(int'(target_q[$urandom_range(0, lim - 1)]) + delta);
        end else begin
          pv = PITCH_W'($urandom);
        end
        send_item(FUNC_PITCH, ENTRY_W'($urandom), pv);
      end
    end
  endtask

  // ---- tests ---------------------------------------------------------------

  // no entries searched: pitches pass unchanged and the lfsr stays put
  task automatic test_empty_table();
    configure(0, 0);
    send_item(FUNC_PITCH, '0, 16'h8000);
    send_item(FUNC_PITCH, '1, 16'h7FFF);
  endtask

  // hand-placed pitches around a tiny table to hit each margin region
  task automatic test_margin_cases();
    send_item(FUNC_LOAD, 6'd0, 16'h8000);  // most negative
    send_item(FUNC_LOAD, 6'd1, 16'h7FFF);  // most positive
    send_item(FUNC_LOAD, 6'd2, 16'h0000);
    send_item(FUNC_LOAD, 6'd3, 16'h0100);  // one in q8.8
    configure(0, 4);
    send_item(FUNC_PITCH, '0, 16'h8000);   // exact hit, margin zero
    send_item(FUNC_PITCH, '0, 16'h7FFF);   // exact hit at the top
    send_item(FUNC_PITCH, '0, 16'h0080);   // tie between entries 2 and 3
    send_item(FUNC_PITCH, '0, 16'h00C8);   // random draw
    configure(32767, 4);
    send_item(FUNC_PITCH, '0, 16'h4000);   // far but within max tolerance
    send_item(FUNC_PITCH, '0, 16'hFFFF);
    configure(100, 4);
    send_item(FUNC_PITCH, '0, 16'd1000);   // well outside, passes
    send_item(FUNC_PITCH, '0, 16'd356);    // margin exactly zero
    send_item(FUNC_PITCH, '0, 16'd355);    // margin just negative
    send_item(FUNC_PITCH, '0, 16'd611);    // last random margin
    send_item(FUNC_PITCH, '0, 16'd612);    // first passing margin
    configure(0, 1);
    send_item(FUNC_PITCH, '0, 16'h7FFF);   // largest possible distance
  endtask

  // long receiver hold-off so the output fills and input stalls
  task automatic test_backpressure();
    configure(40, 3);
    hold_left = 600;
    repeat (30) begin
      send_item(FUNC_PITCH, '0,
                PITCH_W'(int'(target_q[$urandom_range(0, 2)]) + $urandom_range(0, 300) - 150));
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    // fill the whole table first so no search ever sees an unwritten slot
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0)
        send_item(FUNC_LOAD, ENTRY_W'(i), target_q[i - 1]);  // duplicates make ties
      else
        send_item(FUNC_LOAD, ENTRY_W'(i), PITCH_W'($urandom));
    end
    run_phase(200, 0, TABLE_DEPTH);
    run_phase(100, 32767, TABLE_DEPTH);
    run_phase(250, $urandom_range(0, 400), $urandom_range(1, 16));
    run_phase(300, $urandom_range(0, 300), $urandom_range(1, 8));
    run_phase(150, $urandom_range(0, 32767), $urandom_range(0, TABLE_DEPTH));
    run_phase(50, $urandom_range(0, 255), 0);
  endtask

  // table_count above the depth still searches only the real entries
  task automatic test_count_above_depth();
    run_phase(80, $urandom_range(0, 600), 127);
    run_phase(70, $urandom_range(0, 600), $urandom_range(TABLE_DEPTH + 1, 126));
  endtask

  // closing stretch at full rate on both sides
  task automatic test_back_to_back();
    wait_drain();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    run_phase(220, $urandom_range(0, 400), $urandom_range(1, 12));
    run_phase(180, $urandom_range(0, 400), $urandom_range(1, TABLE_DEPTH));
  endtask

  // ---- result sink and checker -----------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    snap_res_t   exp_r;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with no pitch pending");
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tdata !== exp_r.pitch_out)
            report_mismatch($sformatf("pitch_out %h, expected %h", m_axis_tdata,
                                      exp_r.pitch_out));
          if (m_axis_tuser !== exp_r.snapped)
            report_mismatch($sformatf("snapped %b, expected %b", m_axis_tuser,
                                      exp_r.snapped));
        end
      end
      // long hold-off first, then random stall bursts
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---- main sequence -----------------------------------------------------------
  initial begin : main_seq
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_margin_cases();
    test_backpressure();
    test_random_traffic();
    test_count_above_depth();
    test_back_to_back();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("probabilistic_nearest_value_snap regression: pass");
    end else begin
      $display("probabilistic_nearest_value_snap regression: fail");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin : watchdog
    #(30_000_000);
    $display("probabilistic_nearest_value_snap regression: fail");
    $finish;
  end

endmodule
